FILE: rtl/lcc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes, state types and unit interface structs for
// the load cell creep compensator. No dependencies.
package lcc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int ERR_W       = 20;   // creep error in tenths, and quotient width
   localparam int TICK_W      = 16;
   localparam int OP_W        = (SAMPLE_BITS + 1 > ERR_W + 1) ? SAMPLE_BITS + 1 : ERR_W + 1;
   localparam int PROD_W      = OP_W + ERR_W;
   localparam int CNT_W       = $clog2(ERR_W);
   localparam int CSR_W       = (SAMPLE_BITS > ERR_W) ? SAMPLE_BITS : ERR_W;
   localparam int IDX_W       = 3;

   localparam logic [IDX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_NEG_DIR    = 3'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_CREEP  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_MAX_TICKS  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_ZERO       = 3'd4;
   localparam logic [IDX_W-1:0] CSR_SPAN       = 3'd5;

   localparam int CORR_ROUND = 5;
   localparam int CORR_DIV   = 10;
   localparam logic [TICK_W-1:0] TICK_SAT = '1;

   // Divide by ten as a reciprocal multiply: 2**CORR_SHIFT / 10 rounded up,
   // exact for numerators below 2**22.
   localparam int CORR_SHIFT = 24;
   localparam int CORR_NUM_W = ERR_W + 1;
   localparam logic [CORR_NUM_W-1:0] CORR_RECIP = CORR_NUM_W'(1677722);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_LIM,
      SQ_LIM_W,
      SQ_SHIFT,
      SQ_SHIFT_W,
      SQ_NEXT,
      SQ_NEXT_W,
      SQ_CORR,
      SQ_FIN
   } sq_state_type;

   // Command to the shared unit: quotient = (a * b) / d, quotient below 2**ERR_W.
   typedef struct packed {
      logic              start;
      logic [OP_W-1:0]   a;
      logic [ERR_W-1:0]  b;
      logic [OP_W-1:0]   d;
   } md_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ERR_W-1:0]  quot;
   } md_rsp_type;

endpackage

FILE: rtl/load_cell_creep_compensator_unit.sv
`timescale 1ns / 1ps
// Load cell creep compensator top level: register file, sequencer and the
// shared multiply-divide unit. Depends on lcc_pkg and lcc_muldiv.
//
// A passed-through request (compensation off) goes straight to the output
// register; an unstable request first takes the rounded correction, and a
// stable one also makes up to three passes through the shared multiply-divide
// unit (issue, multiply, 20 division steps, hand-back).
// Throughput: one request at a time; req_stall is high until the response is
// loaded into the output register. Reset (synchronous) clears the timer, the
// creep error and the stable history and returns the registers to defaults.
module load_cell_creep_compensator_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [lcc_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                               req_is_stable,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lcc_pkg::SAMPLE_BITS:0]   rsp_corrected,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lcc_pkg::IDX_W-1:0]          csr_index,
   input  logic [lcc_pkg::CSR_W-1:0]          csr_data
);

   localparam int SB = lcc_pkg::SAMPLE_BITS;

   // configuration registers
   logic                          enable_ff;
   logic                          neg_dir_ff;
   logic [lcc_pkg::ERR_W-1:0]     max_creep_ff;
   logic [lcc_pkg::TICK_W-1:0]    max_ticks_ff;
   logic signed [SB-1:0]          zero_ff;
   logic signed [SB-1:0]          span_ff;

   // creep state
   logic [lcc_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [lcc_pkg::ERR_W-1:0]     err_ff, err_in;
   logic                          was_stable_ff, was_stable_in;

   // per-request working registers
   lcc_pkg::sq_state_type         state_ff, state_in;
   logic signed [SB-1:0]          sample_ff, sample_in;
   logic                          stable_ff, stable_in;
   logic [lcc_pkg::ERR_W-1:0]     lim_ff, lim_in;
   logic [lcc_pkg::ERR_W-1:0]     corr_ff, corr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SB:0]            rsp_corrected_ff, rsp_corrected_in;

   lcc_pkg::md_cmd_type           md_cmd;
   lcc_pkg::md_rsp_type           md_rsp;

   logic [lcc_pkg::TICK_W-1:0]    mt;
   logic [lcc_pkg::TICK_W-1:0]    tick_inc;
   logic signed [SB:0]            s_ext, z_ext, span_ext, den;
   logic [SB:0]                   diff;
   logic                          above_span, below_zero, den_pos;
   logic                          out_free;
   lcc_pkg::sq_state_type         after_lim;
   logic [lcc_pkg::CORR_NUM_W-1:0]   corr_num;
   logic [2*lcc_pkg::CORR_NUM_W-1:0] corr_prod;
   logic [lcc_pkg::ERR_W-1:0]        corr_quot;

   lcc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .rsp   (md_rsp)
   );

   // configuration writes; the user must issue them only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         neg_dir_ff   <= 1'b0;
         max_creep_ff <= '0;
         max_ticks_ff <= lcc_pkg::TICK_W'(1);
         zero_ff      <= '0;
         span_ff      <= SB'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcc_pkg::CSR_ENABLE:    enable_ff    <= csr_data[0];
            lcc_pkg::CSR_NEG_DIR:   neg_dir_ff   <= csr_data[0];
            lcc_pkg::CSR_MAX_CREEP: max_creep_ff <= csr_data[lcc_pkg::ERR_W-1:0];
            lcc_pkg::CSR_MAX_TICKS: max_ticks_ff <= csr_data[lcc_pkg::TICK_W-1:0];
            lcc_pkg::CSR_ZERO:      zero_ff      <= csr_data[SB-1:0];
            lcc_pkg::CSR_SPAN:      span_ff      <= csr_data[SB-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // control and creep state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lcc_pkg::SQ_IDLE;
         rsp_valid_ff  <= 1'b0;
         tick_ff       <= '0;
         err_ff        <= '0;
         was_stable_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         tick_ff       <= tick_in;
         err_ff        <= err_in;
         was_stable_ff <= was_stable_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      sample_ff        <= sample_in;
      stable_ff        <= stable_in;
      lim_ff           <= lim_in;
      corr_ff          <= corr_in;
      rsp_corrected_ff <= rsp_corrected_in;
   end

   // shared datapath terms
   always_comb begin
      mt         = (max_ticks_ff == '0) ? lcc_pkg::TICK_W'(1) : max_ticks_ff;
      tick_inc   = (tick_ff != lcc_pkg::TICK_SAT) ? tick_ff + 1'b1 : tick_ff;
      s_ext      = (SB+1)'(sample_ff);
      z_ext      = (SB+1)'(zero_ff);
      span_ext   = (SB+1)'(span_ff);
      diff       = s_ext - z_ext;
      den        = span_ext - z_ext;
      above_span = sample_ff > span_ff;
      below_zero = sample_ff < zero_ff;
      den_pos    = !den[SB] && (den != '0);
      out_free   = !rsp_valid_ff || !rsp_stall;
      // a stable request entering after an unstable one realigns the timer first
      after_lim  = was_stable_ff ? lcc_pkg::SQ_NEXT : lcc_pkg::SQ_SHIFT;
      // rounded correction in whole counts, (error + 5) / 10, by reciprocal
      corr_num   = lcc_pkg::CORR_NUM_W'(err_ff) + lcc_pkg::CORR_NUM_W'(lcc_pkg::CORR_ROUND);
      corr_prod  = {{lcc_pkg::CORR_NUM_W{1'b0}}, corr_num}
                   * {{lcc_pkg::CORR_NUM_W{1'b0}}, lcc_pkg::CORR_RECIP};
      corr_quot  = lcc_pkg::ERR_W'(corr_prod >> lcc_pkg::CORR_SHIFT);
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      sample_in        = sample_ff;
      stable_in        = stable_ff;
      lim_in           = lim_ff;
      corr_in          = corr_ff;
      tick_in          = tick_ff;
      err_in           = err_ff;
      was_stable_in    = was_stable_ff;
      rsp_corrected_in = rsp_corrected_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      md_cmd.start     = 1'b0;
      md_cmd.a         = '0;
      md_cmd.b         = '0;
      md_cmd.d         = '0;

      case (state_ff)
         lcc_pkg::SQ_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               stable_in = req_is_stable;
               corr_in   = '0;
               if (!enable_ff) begin
                  state_in = lcc_pkg::SQ_FIN;
               end else begin
                  // advance the timer, saturate, clamp to the ramp length
                  tick_in  = (tick_inc > mt) ? mt : tick_inc;
                  state_in = req_is_stable ? lcc_pkg::SQ_LIM : lcc_pkg::SQ_CORR;
               end
            end
         end
         lcc_pkg::SQ_LIM: begin
            // error limit proportional to load between zero and span
            if (above_span) begin
               lim_in   = max_creep_ff;
               state_in = after_lim;
            end else if (below_zero || !den_pos) begin
               lim_in   = '0;
               state_in = after_lim;
            end else begin
               md_cmd.start = 1'b1;
               md_cmd.a     = lcc_pkg::OP_W'(diff);
               md_cmd.b     = max_creep_ff;
               md_cmd.d     = lcc_pkg::OP_W'(unsigned'(den));
               state_in     = lcc_pkg::SQ_LIM_W;
            end
         end
         lcc_pkg::SQ_LIM_W: begin
            if (md_rsp.done) begin
               lim_in   = md_rsp.quot;
               state_in = after_lim;
            end
         end
         lcc_pkg::SQ_SHIFT: begin
            // move the timer to the ramp point that matches the present error
            state_in = lcc_pkg::SQ_NEXT;
            if (err_ff <= lim_ff) begin
               if (lim_ff != '0) begin
                  md_cmd.start = 1'b1;
                  md_cmd.a     = lcc_pkg::OP_W'(err_ff);
                  md_cmd.b     = lcc_pkg::ERR_W'(mt);
                  md_cmd.d     = lcc_pkg::OP_W'(lim_ff);
                  state_in     = lcc_pkg::SQ_SHIFT_W;
               end
            end else if (max_creep_ff != lim_ff) begin
               if (err_ff >= max_creep_ff) begin
                  // error at or above max: ramp point clamps to zero
                  tick_in = '0;
               end else begin
                  md_cmd.start = 1'b1;
                  md_cmd.a     = lcc_pkg::OP_W'(max_creep_ff - err_ff);
                  md_cmd.b     = lcc_pkg::ERR_W'(mt);
                  md_cmd.d     = lcc_pkg::OP_W'(max_creep_ff - lim_ff);
                  state_in     = lcc_pkg::SQ_SHIFT_W;
               end
            end
         end
         lcc_pkg::SQ_SHIFT_W: begin
            if (md_rsp.done) begin
               tick_in  = md_rsp.quot[lcc_pkg::TICK_W-1:0];
               state_in = lcc_pkg::SQ_NEXT;
            end
         end
         lcc_pkg::SQ_NEXT: begin
            // move the error along the linear ramp toward the limit
            if (err_ff < lim_ff) begin
               md_cmd.start = 1'b1;
               md_cmd.a     = lcc_pkg::OP_W'(lim_ff);
               md_cmd.b     = lcc_pkg::ERR_W'(tick_ff);
               md_cmd.d     = lcc_pkg::OP_W'(mt);
               state_in     = lcc_pkg::SQ_NEXT_W;
            end else if (err_ff > lim_ff) begin
               md_cmd.start = 1'b1;
               md_cmd.a     = lcc_pkg::OP_W'(max_creep_ff - lim_ff);
               md_cmd.b     = lcc_pkg::ERR_W'(tick_ff);
               md_cmd.d     = lcc_pkg::OP_W'(mt);
               state_in     = lcc_pkg::SQ_NEXT_W;
            end else begin
               state_in = lcc_pkg::SQ_CORR;
            end
         end
         lcc_pkg::SQ_NEXT_W: begin
            // both ramps land within 0..max, so no clamp is needed
            if (md_rsp.done) begin
               if (err_ff < lim_ff) begin
                  err_in = md_rsp.quot;
               end else begin
                  err_in = max_creep_ff - md_rsp.quot;
               end
               state_in = lcc_pkg::SQ_CORR;
            end
         end
         lcc_pkg::SQ_CORR: begin
            // take the rounded correction and record the stable history
            was_stable_in = stable_ff;
            corr_in       = corr_quot;
            state_in      = lcc_pkg::SQ_FIN;
         end
         lcc_pkg::SQ_FIN: begin
            // hold until the output register is free, then load the response
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_dir_ff) begin
                  rsp_corrected_in = s_ext + (SB+1)'(corr_ff);
               end else begin
                  rsp_corrected_in = s_ext - (SB+1)'(corr_ff);
               end
               state_in = lcc_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = lcc_pkg::SQ_IDLE;
         end
      endcase
   end

   assign req_stall     = (state_ff != lcc_pkg::SQ_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = rsp_corrected_ff;

endmodule

FILE: rtl/lcc_muldiv.sv
`timescale 1ns / 1ps
// Shared multiply-then-divide unit: one registered multiply, then one
// restoring division step per cycle. Depends on lcc_pkg.
module lcc_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  lcc_pkg::md_cmd_type cmd,
   output lcc_pkg::md_rsp_type rsp
);

   lcc_pkg::md_state_type state_ff, state_in;

   logic [lcc_pkg::OP_W-1:0]   a_ff, a_in;
   logic [lcc_pkg::ERR_W-1:0]  b_ff, b_in;
   logic [lcc_pkg::OP_W-1:0]   d_ff, d_in;
   logic [lcc_pkg::OP_W-1:0]   rem_ff, rem_in;
   logic [lcc_pkg::ERR_W-1:0]  dvd_ff, dvd_in;
   logic [lcc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       done_ff, done_in;

   logic [lcc_pkg::PROD_W-1:0] prod;
   logic [lcc_pkg::OP_W:0]     trial;
   logic                       ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcc_pkg::MD_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   always_comb begin
      prod  = {{lcc_pkg::ERR_W{1'b0}}, a_ff} * {{lcc_pkg::OP_W{1'b0}}, b_ff};
      trial = {rem_ff, dvd_ff[lcc_pkg::ERR_W-1]};
      ge    = trial >= {1'b0, d_ff};

      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;

      case (state_ff)
         lcc_pkg::MD_IDLE: begin
            if (cmd.start) begin
               a_in     = cmd.a;
               b_in     = cmd.b;
               d_in     = cmd.d;
               state_in = lcc_pkg::MD_MUL;
            end
         end
         lcc_pkg::MD_MUL: begin
            // upper part stays below the divisor since the quotient fits ERR_W bits
            rem_in   = prod[lcc_pkg::PROD_W-1:lcc_pkg::ERR_W];
            dvd_in   = prod[lcc_pkg::ERR_W-1:0];
            cnt_in   = '0;
            state_in = lcc_pkg::MD_DIV;
         end
         lcc_pkg::MD_DIV: begin
            if (ge) begin
               rem_in = lcc_pkg::OP_W'(trial - {1'b0, d_ff});
            end else begin
               rem_in = trial[lcc_pkg::OP_W-1:0];
            end
            dvd_in = {dvd_ff[lcc_pkg::ERR_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lcc_pkg::CNT_W'(lcc_pkg::ERR_W - 1)) begin
               done_in  = 1'b1;
               state_in = lcc_pkg::MD_IDLE;
            end
         end
         default: begin
            state_in = lcc_pkg::MD_IDLE;
         end
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.quot = dvd_ff;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for load_cell_creep_compensator_unit: directed and random weighing
// requests, each checked against an in-bench creep predictor. Depends on lcc_pkg and the RTL.
module testbench;

   localparam int     SB            = lcc_pkg::SAMPLE_BITS;
   localparam int     CLOCK_HALF    = 4;
   localparam int     RESET_CYCLES  = 8;
   localparam int     IDLE_LIMIT    = 4000;   // worst request plus both longest stalls, many times over
   localparam int     SETTLE_CYCLES = 200;    // well beyond the slowest stable request
   localparam int     REPORT_LIMIT  = 10;
   localparam int     PHASE_ITEMS   = 125;
   localparam longint SAMPLE_MAX    = (longint'(1) << (SB - 1)) - 1;
   localparam longint SAMPLE_MIN    = -(longint'(1) << (SB - 1));
   localparam longint CREEP_FULL    = 655350;
   localparam longint TICKS_FULL    = 65535;

   typedef logic signed [SB-1:0] sample_type;
   typedef logic signed [SB:0]   corrected_type;

   typedef struct {
      sample_type    reading;
      logic          is_stable;
      corrected_type corrected;
   } weighing_type;

   // Block ports; the inputs are driven to known values from time zero.
   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   sample_type                    req_sample    = '0;
   logic                          req_is_stable = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   corrected_type                 rsp_corrected;
   logic                          csr_valid     = 1'b0;
   logic                          csr_ready;
   logic [lcc_pkg::IDX_W-1:0]     csr_index     = '0;
   logic [lcc_pkg::CSR_W-1:0]     csr_data      = '0;

   // Predictor copy of the register file, at its reset values.
   bit     cal_enable    = 1'b0;
   bit     cal_neg_dir   = 1'b0;
   longint cal_max_creep = 0;
   longint cal_max_ticks = 1;
   longint cal_zero      = 0;
   longint cal_span      = 1;

   // Predictor copy of the creep state.
   longint creep_ticks  = 0;
   longint creep_tenths = 0;
   bit     last_stable  = 1'b0;

   weighing_type pending_weighings[$];

   int requests_sent  = 0;
   int responses_seen = 0;
   int mismatches     = 0;
   int settings_used  = 0;
   bit idle_on        = 1'b1;
   int stall_run      = 0;
   int free_run       = 0;

   load_cell_creep_compensator_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_is_stable (req_is_stable),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_corrected (rsp_corrected),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Creep predictor
   // ------------------------------------------------------------------

   // Error the load would settle to: full creep above span, none below zero,
   // proportional in between.
   function automatic longint load_limit(longint s, longint mx);
      if (s > cal_span) return mx;
      if (s < cal_zero) return 0;
      if (cal_span - cal_zero <= 0) return 0;
      return mx * (s - cal_zero) / (cal_span - cal_zero);
   endfunction

   // Point on the ramp towards lim that the present error sits at; keep the
   // timer where it is when no such point exists.
   function automatic longint matched_ticks(longint lim, longint mx, longint mt, longint t);
      longint r;
      if (creep_tenths <= lim) begin
         if (lim == 0) return t;
         r = creep_tenths * mt / lim;
      end else begin
         if (mx == lim) return t;
         r = (mx - creep_tenths) * mt / (mx - lim);
      end
      if (r < 0) r = 0;
      if (r > mt) r = mt;
      return r;
   endfunction

   function automatic longint ramped_tenths(longint lim, longint mx, longint mt, longint t);
      if (creep_tenths < lim) return lim * t / mt;
      if (creep_tenths > lim) return (lim - mx) * t / mt + mx;
      return creep_tenths;
   endfunction

   function automatic corrected_type compensate(sample_type reading, logic stable);
      longint s, mx, mt, t, lim, corr;
      s  = longint'(reading);
      mx = cal_max_creep;
      mt = (cal_max_ticks == 0) ? 1 : cal_max_ticks;
      // Pass through untouched, leaving all creep state alone.
      if (!cal_enable) return corrected_type'(reading);
      if (creep_ticks < longint'(lcc_pkg::TICK_SAT)) creep_ticks++;
      if (creep_ticks > mt) creep_ticks = mt;
      if (stable) begin
         t   = creep_ticks;
         lim = load_limit(s, mx);
         if (!last_stable) begin
            t = matched_ticks(lim, mx, mt, t);
            creep_ticks = t;
         end
         creep_tenths = ramped_tenths(lim, mx, mt, t);
         if (creep_tenths < 0) creep_tenths = 0;
         else if (creep_tenths > mx) creep_tenths = mx;
      end
      corr = (creep_tenths + lcc_pkg::CORR_ROUND) / lcc_pkg::CORR_DIV;
      last_stable = stable;
      return corrected_type'(cal_neg_dir ? s + corr : s - corr);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic sample_type fit_sample(longint v);
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return sample_type'(v);
   endfunction

   // Offer one request, hold it until accepted, then log its expected response.
   task automatic send_request(input longint value, input logic stable);
      int           gap;
      weighing_type w;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample    = fit_sample(value);
      req_is_stable = stable;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      w.reading   = req_sample;
      w.is_stable = stable;
      w.corrected = compensate(req_sample, stable);
      pending_weighings.push_back(w);
      requests_sent++;
   endtask

   // Drop the request valid and hold until every response is back.
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_weighings.size() != 0) @(negedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_register(input logic [lcc_pkg::IDX_W-1:0] idx, input longint value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = lcc_pkg::CSR_W'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lcc_pkg::CSR_ENABLE:    cal_enable    = csr_data[0];
         lcc_pkg::CSR_NEG_DIR:   cal_neg_dir   = csr_data[0];
         lcc_pkg::CSR_MAX_CREEP: cal_max_creep = longint'(csr_data[lcc_pkg::ERR_W-1:0]);
         lcc_pkg::CSR_MAX_TICKS: cal_max_ticks = longint'(csr_data[lcc_pkg::TICK_W-1:0]);
         lcc_pkg::CSR_ZERO:      cal_zero      = longint'($signed(csr_data[SB-1:0]));
         lcc_pkg::CSR_SPAN:      cal_span      = longint'($signed(csr_data[SB-1:0]));
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic program_registers(input bit en, input bit neg, input longint mx,
                                    input longint mt, input longint zero, input longint span);
      drain_responses();
      write_register(lcc_pkg::CSR_ENABLE, longint'(en));
      write_register(lcc_pkg::CSR_NEG_DIR, longint'(neg));
      write_register(lcc_pkg::CSR_MAX_CREEP, mx);
      write_register(lcc_pkg::CSR_MAX_TICKS, mt);
      write_register(lcc_pkg::CSR_ZERO, zero);
      write_register(lcc_pkg::CSR_SPAN, span);
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Compensation off: samples come back as they went in.
   task automatic test_passthrough();
      program_registers(1'b0, 1'b0, 0, 1, 0, 1);
      send_request(SAMPLE_MIN, 1'b1);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(0, 1'b1);
   endtask

   // Full creep at full scale, then push the output past the sample range both ways.
   task automatic test_full_scale_creep();
      program_registers(1'b1, 1'b0, CREEP_FULL, 1, 0, 1000);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MAX, 1'b1);
      send_request(SAMPLE_MIN, 1'b0);
      drain_responses();
      write_register(lcc_pkg::CSR_NEG_DIR, 1);
      send_request(SAMPLE_MAX, 1'b0);
   endtask

   // A zero tick count acts as one; the error collapses in a single step, and
   // the later stable edge, with no limit and the error at the maximum, moves the timer to zero.
   task automatic test_zero_max_ticks();
      program_registers(1'b1, 1'b1, 300, 0, -100, 100);
      send_request(-200, 1'b1);
      send_request(-200, 1'b0);
      send_request(-200, 1'b1);
   endtask

   task automatic test_equal_calibration();
      program_registers(1'b1, 1'b0, 2000, 3, 100, 100);
      send_request(101, 1'b1);
      send_request(100, 1'b1);
      send_request(99, 1'b1);
   endtask

   // Span below zero: the above-span rule wins before the below-zero one.
   task automatic test_inverted_calibration();
      program_registers(1'b1, 1'b1, 5000, 2, 1000, -1000);
      send_request(2000, 1'b1);
      send_request(0, 1'b1);
      send_request(-2000, 1'b1);
   endtask

   // Build a large error, then lower the maximum beneath it.
   task automatic test_error_above_max();
      program_registers(1'b1, 1'b0, CREEP_FULL, 4, 0, 1000);
      repeat (4) send_request(2000, 1'b1);
      drain_responses();
      write_register(lcc_pkg::CSR_MAX_CREEP, 1000);
      send_request(2000, 1'b0);
      send_request(2000, 1'b1);     // limit equals the maximum, error above it
      send_request(-50, 1'b0);
      send_request(-50, 1'b1);
      send_request(500, 1'b1);
   endtask

   // Random settings, mostly settling-then-stable bursts around a load level,
   // with some raw noise mixed in.
   task automatic test_random_ramps();
      int                phase, sent, burst_len, settle_len, i, r;
      longint            lo, hi, width, level, low_cal, high_cal;
      logic [SB-1:0]     raw;
      for (phase = 0; phase < 10; phase++) begin
         idle_on = (phase % 3 != 2);
         lo    = SAMPLE_MIN + longint'($urandom_range(0, 16777214));
         width = $urandom_range(0, 1) ? longint'($urandom_range(1, 4000))
                                      : longint'($urandom_range(1, 16777215));
         hi    = lo + width;
         if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
         case (phase % 5)
            0: program_registers(1'b1, 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 3) == 0) ? 0
                                    : longint'($urandom_range(1, int'(CREEP_FULL))),
                                 longint'($urandom_range(1, 48)), lo, hi);
            1: program_registers(1'b1, 1'($urandom_range(0, 1)), CREEP_FULL,
                                 (phase < 5) ? TICKS_FULL : 1, SAMPLE_MIN, SAMPLE_MAX);
            2: program_registers(1'b1, 1'($urandom_range(0, 1)),
                                 longint'($urandom_range(1, int'(CREEP_FULL))),
                                 longint'($urandom_range(1, 32)), hi, lo);
            3: program_registers(1'b1, 1'($urandom_range(0, 1)),
                                 longint'($urandom_range(1, int'(CREEP_FULL))),
                                 longint'($urandom_range(1, 32)), lo, lo);
            default: program_registers(1'b0, 1'($urandom_range(0, 1)),
                                       longint'($urandom_range(0, int'(CREEP_FULL))),
                                       longint'($urandom_range(1, int'(TICKS_FULL))),
                                       lo, hi);
         endcase
         low_cal  = (cal_zero < cal_span) ? cal_zero : cal_span;
         high_cal = (cal_zero < cal_span) ? cal_span : cal_zero;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               raw = SB'($urandom);
               send_request(longint'($signed(raw)), 1'($urandom_range(0, 1)));
               sent++;
            end else begin
               r = int'($urandom_range(0, 99));
               if (r < 10) level = low_cal - longint'($urandom_range(1, 5000));
               else if (r < 20) level = high_cal + longint'($urandom_range(1, 5000));
               else if (r < 23) level = $urandom_range(0, 1) ? cal_zero : cal_span;
               else level = low_cal + (high_cal - low_cal) * longint'($urandom_range(0, 1000))
                                      / 1000;
               burst_len  = int'($urandom_range(1, 40));
               settle_len = int'($urandom_range(0, 3));
               for (i = 0; i < burst_len; i++) begin
                  send_request(level + longint'($urandom_range(0, 16)) - 8, i >= settle_len);
               end
               sent += burst_len;
               // Hold off now and then until the block has fully caught up.
               if ($urandom_range(0, 99) < 4) drain_responses();
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Stall in runs drawn like the sender's gaps, separated by short free runs.
   always @(negedge clock) begin
      if (stall_run == 0 && free_run == 0) begin
         stall_run = pick_gap();
         free_run  = int'($urandom_range(1, 8));
      end
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
         free_run--;
      end
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      weighing_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (pending_weighings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response %0d with no request outstanding", $time, rsp_corrected);
         end else begin
            w = pending_weighings.pop_front();
            if (rsp_corrected !== w.corrected) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: sample %0d stable %0b: corrected expected %0d, got %0d",
                           $time, w.reading, w.is_stable, w.corrected, rsp_corrected);
            end
         end
      end
   end

   // End the run once nothing has moved on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL load_cell_creep_compensator_unit");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_passthrough();
      test_full_scale_creep();
      test_zero_max_ticks();
      test_equal_calibration();
      test_inverted_calibration();
      test_error_above_max();
      test_random_ramps();

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests and %0d responses over %0d register settings.",
               requests_sent, responses_seen, settings_used);
      $display("Pass-through, full-scale creep, equal and inverted calibration, lowered maximum.");
      if (mismatches == 0 && pending_weighings.size() == 0)
         $display("PASS load_cell_creep_compensator_unit");
      else
         $display("FAIL load_cell_creep_compensator_unit");
      $finish;
   end

endmodule
